[rtl/core/utf8_stream_decoder_defines.svh]
// assertion macros shared by the utf8 stream decoder rtl
// no dependencies; files that check their own logic include this header
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define UTF8D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8d check failed");

// next-cycle implication, held off while reset is low
`define UTF8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8d check failed");

`endif

[rtl/core/utf8d_pkg.sv]
// types and constants of the utf8 stream decoder
// no dependencies; used by the interfaces and every module
package utf8d_pkg;

    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000080;
    localparam logic [CP_W-1:0] MAX_LEN2    = 21'h0007FF;
    localparam logic [CP_W-1:0] MIN_LEN3    = 21'h000800;
    localparam logic [CP_W-1:0] MAX_LEN3    = 21'h00FFFF;
    localparam logic [CP_W-1:0] MIN_LEN4    = 21'h010000;
    localparam logic [CP_W-1:0] MAX_LEN4    = 21'h10FFFF;
    localparam logic [7:0]      BAD_LEAD    = 8'hF8;

    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;

    // what the back end must do with the first result of a command
    typedef enum logic [1:0] {
        K_PLAIN = 2'd0,   // value passes through as is
        K_BAD   = 2'd1,   // replacement, malformed
        K_CHECK = 2'd2    // finished sequence, range and surrogate check
    } t_kind;

    // one queued command: up to two results caused by one input byte
    typedef struct packed {
        t_kind             kind;
        logic [CP_W-1:0]   value;
        logic [LEN_W-1:0]  len;
        logic              has_second;
        logic              second_bad;
        logic [6:0]        second_byte;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

[rtl/core/utf8d_stream_ifs.sv]
// valid/ready channels of the utf8 stream decoder: byte in, code point out
// depends on utf8d_pkg
interface utf8d_byte_if import utf8d_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface utf8d_cp_if import utf8d_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CP_W-1:0]   code_point;
    logic              malformed;
    logic [LEN_W-1:0]  seq_length;
    logic              last_of_run;

    modport source (output valid, output code_point, output malformed,
                    output seq_length, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input malformed,
                    input seq_length, input last_of_run, output ready);
endinterface

[rtl/core/utf8d_front.sv]
// front end: accepts bytes, tracks the open sequence, queues result commands
// depends on utf8d_pkg and the stream interfaces
`include "utf8_stream_decoder_defines.svh"

module utf8d_front import utf8d_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    utf8d_byte_if.sink        i_byte,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_cmd              o_push_cmd
);

    logic [CP_W-1:0]  r_partial, n_partial;
    logic [LEN_W-1:0] r_exp_len, n_exp_len;
    logic [LEN_W-1:0] r_seen, n_seen;

    logic             accept;
    logic [7:0]       b;
    logic             b_ascii, b_cont, b_lead;
    logic [LEN_W-1:0] lead_len, seen_inc;
    logic [CP_W-1:0]  lead_val, grown;

    assign i_byte.ready = !i_q_status.full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.byte_in;

    // byte class and lead decode
    always_comb begin
        b_ascii = !b[7];
        b_cont  = (b[7:6] == 2'b10);
        b_lead  = (b[7:6] == 2'b11) && (b < BAD_LEAD);
        priority if (!b[5]) begin
            lead_len = LEN_2;
            lead_val = {16'd0, b[4:0]};
        end else if (!b[4]) begin
            lead_len = LEN_3;
            lead_val = {17'd0, b[3:0]};
        end else begin
            lead_len = LEN_4;
            lead_val = {18'd0, b[2:0]};
        end
        grown    = {r_partial[CP_W-7:0], b[5:0]};
        seen_inc = r_seen + LEN_1;
    end

    // sequence tracking and command build
    always_comb begin
        n_partial  = r_partial;
        n_exp_len  = r_exp_len;
        n_seen     = r_seen;
        o_push     = 1'b0;
        o_push_cmd = '0;
        if (accept) begin
            if (r_exp_len == LEN_NONE) begin
                // no sequence open: decode the byte afresh
                if (b_lead) begin
                    n_partial = lead_val;
                    n_exp_len = lead_len;
                    n_seen    = LEN_1;
                end else begin
                    o_push           = 1'b1;
                    o_push_cmd.kind  = b_ascii ? K_PLAIN : K_BAD;
                    o_push_cmd.value = {14'd0, b[6:0]};
                    o_push_cmd.len   = LEN_1;
                end
            end else if (b_cont) begin
                // continuation adds six payload bits
                n_partial = grown;
                n_seen    = seen_inc;
                if (seen_inc >= r_exp_len) begin
                    o_push           = 1'b1;
                    o_push_cmd.kind  = K_CHECK;
                    o_push_cmd.value = grown;
                    o_push_cmd.len   = r_exp_len;
                    n_partial        = '0;
                    n_exp_len        = LEN_NONE;
                    n_seen           = LEN_NONE;
                end
            end else begin
                // interrupted sequence, then decode this byte afresh
                o_push                 = 1'b1;
                o_push_cmd.kind        = K_BAD;
                o_push_cmd.len         = r_seen;
                o_push_cmd.has_second  = !b_lead;
                o_push_cmd.second_bad  = !b_ascii;
                o_push_cmd.second_byte = b[6:0];
                if (b_lead) begin
                    n_partial = lead_val;
                    n_exp_len = lead_len;
                    n_seen    = LEN_1;
                end else begin
                    n_partial = '0;
                    n_exp_len = LEN_NONE;
                    n_seen    = LEN_NONE;
                end
            end
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_exp_len <= LEN_NONE;
            r_seen    <= LEN_NONE;
        end else begin
            r_partial <= n_partial;
            r_exp_len <= n_exp_len;
            r_seen    <= n_seen;
        end
    end

    `UTF8D_ASSERT_SAME(a_seen_below_len, i_clk, i_rst_n, r_exp_len != LEN_NONE, r_seen != LEN_NONE && r_seen < r_exp_len)

endmodule

[rtl/core/utf8d_cmd_queue.sv]
// small command queue between the front and back ends, head shown ahead
// depends on utf8d_pkg
`include "utf8_stream_decoder_defines.svh"

module utf8d_cmd_queue import utf8d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_push_cmd,
    input  logic       i_pop,
    output t_cmd       o_head,
    output t_q_status  o_status
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == Q_CW'(Q_DEPTH));

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `UTF8D_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_push, !o_status.full)
    `UTF8D_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_status.empty)
    `UTF8D_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

[rtl/core/utf8d_back.sv]
// back end: range checks finished sequences and serializes results
// depends on utf8d_pkg and the stream interfaces
`include "utf8_stream_decoder_defines.svh"

module utf8d_back import utf8d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    utf8d_cp_if.source o_cp
);

    logic              r_valid;
    logic              r_phase;   // second result of the head still owed
    logic [CP_W-1:0]   r_cp;
    logic              r_bad;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;

    logic              load, value_ok;
    logic [CP_W-1:0]   lo, hi;
    logic [CP_W-1:0]   first_cp, second_cp;
    logic              first_bad;

    assign load  = !r_valid || o_cp.ready;
    assign o_pop = load && (r_phase || (!i_q_status.empty && !i_head.has_second));

    // legal range for the sequence length, surrogates excluded
    always_comb begin
        unique case (i_head.len)
            LEN_2:   begin lo = MIN_LEN2; hi = MAX_LEN2; end
            LEN_3:   begin lo = MIN_LEN3; hi = MAX_LEN3; end
            default: begin lo = MIN_LEN4; hi = MAX_LEN4; end
        endcase
        value_ok = (i_head.value >= lo) && (i_head.value <= hi)
                   && !((i_head.value >= SURR_LO) && (i_head.value <= SURR_HI));
    end

    // first and second result of the head command
    always_comb begin
        unique case (i_head.kind)
            K_PLAIN: begin first_cp = i_head.value; first_bad = 1'b0; end
            K_CHECK: begin
                first_cp  = value_ok ? i_head.value : REPLACEMENT;
                first_bad = !value_ok;
            end
            default: begin first_cp = REPLACEMENT; first_bad = 1'b1; end
        endcase
        second_cp = i_head.second_bad ? REPLACEMENT : {14'd0, i_head.second_byte};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            if (r_phase) begin
                r_valid <= 1'b1;
                r_phase <= 1'b0;
            end else begin
                r_valid <= !i_q_status.empty;
                r_phase <= !i_q_status.empty && i_head.has_second;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_phase) begin
                r_cp   <= second_cp;
                r_bad  <= i_head.second_bad;
                r_len  <= LEN_1;
                r_last <= 1'b1;
            end else begin
                r_cp   <= first_cp;
                r_bad  <= first_bad;
                r_len  <= i_head.len;
                r_last <= !i_head.has_second;
            end
        end
    end

    assign o_cp.valid       = r_valid;
    assign o_cp.code_point  = r_cp;
    assign o_cp.malformed   = r_bad;
    assign o_cp.seq_length  = r_len;
    assign o_cp.last_of_run = r_last;

    `UTF8D_ASSERT_SAME(a_phase_has_word, i_clk, i_rst_n, r_phase, r_valid && !r_last && !i_q_status.empty)
    `UTF8D_ASSERT_SAME(a_len_range, i_clk, i_rst_n, r_valid, r_len != LEN_NONE && r_len <= LEN_4)

endmodule

[rtl/core/utf8_stream_decoder.sv]
// utf8 stream decoder top: front end, command queue, back end
// an accepted byte's results pass through the command queue, then the back end's output register
// throughput: one byte per cycle while the queue is not full; a byte that interrupts a sequence and gives
//   two results holds the output for two words, absorbed by a 4-entry queue
// reset (synchronous, active low) closes any open sequence, empties the queue
//   and drops the output word
module utf8_stream_decoder import utf8d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8d_byte_if.sink  i_byte,
    utf8d_cp_if.source  o_cp
);

    logic      push, pop;
    t_cmd      push_cmd, head;
    t_q_status q_status;

    // byte intake and sequence tracking
    utf8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    // decoupling queue
    utf8d_cmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    // result checking and output
    utf8d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_cp       (o_cp)
    );

endmodule

[bench/utf8_stream_decoder_tb.sv]
// self-checking bench for the utf8 stream decoder: directed and random byte streams
// depends on utf8d_pkg, the utf8d stream interfaces and the utf8_stream_decoder rtl
module utf8_stream_decoder_tb import utf8d_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CONT_BASE = 8'h80;
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] LEAD4     = 8'hF0;
    localparam int         DRAIN_CYCLES = 16;
    localparam longint     TIMEOUT_NS   = 3_000_000;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             malformed;
        logic [LEN_W-1:0] seq_length;
        logic             last_of_run;
    } t_cp_word;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   cp_ch ();

    utf8_stream_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_cp    (cp_ch)
    );

    // decoder state mirrored by the predictor
    logic [CP_W-1:0]  seq_value;
    logic [LEN_W-1:0] seq_len;
    logic [LEN_W-1:0] seq_got;

    t_cp_word pending_cps[$];
    t_cp_word got_word;
    t_cp_word want_word;
    int       error_count;
    int       bytes_sent;
    int       burst_left;
    bit       sender_gaps;
    t_rx_mode rx_mode;
    int       rx_left;
    int       rx_tick;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // range and surrogate check for a finished multi-byte sequence
    function automatic bit scalar_legal(input logic [CP_W-1:0] v, input logic [LEN_W-1:0] n);
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        case (n)
            LEN_2: begin
                lo = MIN_LEN2;
                hi = MAX_LEN2;
            end
            LEN_3: begin
                lo = MIN_LEN3;
                hi = MAX_LEN3;
            end
            default: begin
                lo = MIN_LEN4;
                hi = MAX_LEN4;
            end
        endcase
        return (v >= lo) && (v <= hi) && !((v >= SURR_LO) && (v <= SURR_HI));
    endfunction

    // byte seen with no sequence open; returns 1 when it yields a word
    function automatic bit decode_fresh(input logic [7:0] b, output t_cp_word w);
        w = '{code_point: {13'd0, b}, malformed: 1'b0, seq_length: LEN_1, last_of_run: 1'b1};
        if (b < CONT_BASE)
            return 1'b1;
        if (b < LEAD2 || b >= BAD_LEAD) begin
            w.code_point = REPLACEMENT;
            w.malformed  = 1'b1;
            return 1'b1;
        end
        if (b < LEAD3) begin
            seq_value = {16'd0, b[4:0]};
            seq_len   = LEN_2;
        end else if (b < LEAD4) begin
            seq_value = {17'd0, b[3:0]};
            seq_len   = LEN_3;
        end else begin
            seq_value = {18'd0, b[2:0]};
            seq_len   = LEN_4;
        end
        seq_got = LEN_1;
        return 1'b0;
    endfunction

    // expected words for one accepted byte
    function automatic void predict_byte(input logic [7:0] b);
        t_cp_word w;
        t_cp_word w2;
        if (seq_len == LEN_NONE) begin
            if (decode_fresh(b, w))
                pending_cps.push_back(w);
        end else if ((b & LEAD2) == CONT_BASE) begin
            seq_value = {seq_value[CP_W-7:0], b[5:0]};
            seq_got   = seq_got + LEN_1;
            if (seq_got >= seq_len) begin
                w.last_of_run = 1'b1;
                w.seq_length  = seq_len;
                if (scalar_legal(seq_value, seq_len)) begin
                    w.code_point = seq_value;
                    w.malformed  = 1'b0;
                end else begin
                    w.code_point = REPLACEMENT;
                    w.malformed  = 1'b1;
                end
                pending_cps.push_back(w);
                seq_value = '0;
                seq_len   = LEN_NONE;
                seq_got   = LEN_NONE;
            end
        end else begin
            // interrupted sequence: flush what was seen, then decode the byte afresh
            w = '{code_point: REPLACEMENT, malformed: 1'b1, seq_length: seq_got,
                  last_of_run: 1'b1};
            seq_value = '0;
            seq_len   = LEN_NONE;
            seq_got   = LEN_NONE;
            if (decode_fresh(b, w2)) begin
                w.last_of_run = 1'b0;
                pending_cps.push_back(w);
                pending_cps.push_back(w2);
            end else begin
                pending_cps.push_back(w);
            end
        end
    endfunction

    // scoreboard: predict on byte handshakes, check on code point handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready)
                predict_byte(byte_ch.byte_in);
            if (cp_ch.valid && cp_ch.ready) begin
                got_word = '{cp_ch.code_point, cp_ch.malformed, cp_ch.seq_length,
                             cp_ch.last_of_run};
                if (pending_cps.size() == 0) begin
                    $display("%t: unexpected word, expected none, got %h", $time, got_word);
                    error_count++;
                end else begin
                    want_word = pending_cps.pop_front();
                    if (got_word.code_point !== want_word.code_point) begin
                        $display("%t: code_point expected %h got %h", $time,
                                 want_word.code_point, got_word.code_point);
                        error_count++;
                    end
                    if (got_word.malformed !== want_word.malformed) begin
                        $display("%t: malformed expected %b got %b", $time,
                                 want_word.malformed, got_word.malformed);
                        error_count++;
                    end
                    if (got_word.seq_length !== want_word.seq_length) begin
                        $display("%t: seq_length expected %0d got %0d", $time,
                                 want_word.seq_length, got_word.seq_length);
                        error_count++;
                    end
                    if (got_word.last_of_run !== want_word.last_of_run) begin
                        $display("%t: last_of_run expected %b got %b", $time,
                                 want_word.last_of_run, got_word.last_of_run);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver back-pressure: switches between open, light, periodic and heavy stalls
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     cp_ch.ready <= 1'b1;
            RX_LIGHT:    cp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: cp_ch.ready <= ((rx_tick % 7) < 3);
            default:     cp_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
        rx_tick <= rx_tick + 1;
    end

    // one byte over the input channel, in bursts with random gaps between them when sender_gaps is set
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = sender_gaps ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    // sends the low n bytes of run, most significant first
    task automatic send_run(input logic [31:0] run, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_byte(run[8*i +: 8]);
    endtask

    // hold the sender until every expected word has come out
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_cps.size() != 0);
    endtask

    // encoding of v in n bytes, right aligned; v bits above the form are dropped
    function automatic logic [31:0] utf8_form(input logic [CP_W-1:0] v, input int n);
        case (n)
            1: return {24'd0, 1'b0, v[6:0]};
            2: return {16'd0, LEAD2 | {3'd0, v[10:6]}, CONT_BASE | {2'd0, v[5:0]}};
            3: return {8'd0, LEAD3 | {4'd0, v[15:12]}, CONT_BASE | {2'd0, v[11:6]},
                       CONT_BASE | {2'd0, v[5:0]}};
            default: return {LEAD4 | {5'd0, v[20:18]}, CONT_BASE | {2'd0, v[17:12]},
                             CONT_BASE | {2'd0, v[11:6]}, CONT_BASE | {2'd0, v[5:0]}};
        endcase
    endfunction

    // ascii extremes, stray continuation, invalid lead
    task automatic test_single_bytes();
        send_run(32'h00_7F_80_F8, 4);
    endtask

    // smallest two-byte scalar and an overlong form
    task automatic test_two_byte();
        send_run(32'hC2_80, 2);
        send_run(32'hC1_BF, 2);
    endtask

    // smallest three-byte scalar and a surrogate
    task automatic test_three_byte();
        send_run(32'hE0_A0_80, 3);
        send_run(32'hED_A0_80, 3);
    endtask

    // largest scalar and the first value above it
    task automatic test_four_byte();
        send_run(32'hF4_8F_BF_BF, 4);
        send_run(32'hF4_90_80_80, 4);
    endtask

    // sequences cut short by ascii and by an invalid lead, both giving two words
    task automatic test_interrupted();
        send_run(32'hC3_41, 2);
        send_run(32'hE2_82_F8, 3);
    endtask

    // mostly well-formed text with random scalars, plus raw, truncated and noise bytes
    task automatic test_random_stream(input int n_bytes, input bit gaps);
        int              stop_at;
        int              pick;
        int              n;
        int              keep;
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
        logic [CP_W-1:0] v;
        sender_gaps = gaps;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            n    = $urandom_range(1, 4);
            if (pick < 55) begin
                case (n)
                    1: begin lo = '0;       hi = MIN_LEN2 - 1; end
                    2: begin lo = MIN_LEN2; hi = MAX_LEN2;     end
                    3: begin lo = MIN_LEN3; hi = MAX_LEN3;     end
                    default: begin lo = MIN_LEN4; hi = MAX_LEN4; end
                endcase
                case ($urandom_range(0, 7))
                    0: v = lo;
                    1: v = hi;
                    default: v = CP_W'($urandom_range(int'(lo), int'(hi)));
                endcase
                send_run(utf8_form(v, n), n);
            end else if (pick < 75) begin
                // raw payload: overlong, surrogate and out-of-range forms
                v = CP_W'($urandom);
                send_run(utf8_form(v, n), n);
            end else if (pick < 87) begin
                n    = $urandom_range(2, 4);
                keep = $urandom_range(1, n - 1);
                v    = CP_W'($urandom);
                send_run(utf8_form(v, n) >> (8 * (n - keep)), keep);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.byte_in = '0;
        cp_ch.ready     = 1'b0;
        seq_value       = '0;
        seq_len         = LEN_NONE;
        seq_got         = LEN_NONE;
        error_count     = 0;
        bytes_sent      = 0;
        burst_left      = 0;
        sender_gaps     = 1'b1;
        rx_mode         = RX_OPEN;
        rx_left         = 0;
        rx_tick         = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_bytes();
        test_two_byte();
        test_three_byte();
        test_four_byte();
        test_interrupted();
        wait_drained();
        test_random_stream(300, 1'b0);
        wait_drained();
        test_random_stream(500, 1'b1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("utf8_stream_decoder_tb: done, clean");
        else
            $display("utf8_stream_decoder_tb: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("utf8_stream_decoder_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_stream_ifs.sv
rtl/core/utf8d_front.sv
rtl/core/utf8d_cmd_queue.sv
rtl/core/utf8d_back.sv
rtl/core/utf8_stream_decoder.sv
bench/utf8_stream_decoder_tb.sv
